// ----- src/fully_associative_tlb_lookup_fill_unit_assert.svh -----
// Assertion macros for the TLB lookup and fill unit
`ifndef FULLY_ASSOCIATIVE_TLB_LOOKUP_FILL_UNIT_ASSERT_SVH
`define FULLY_ASSOCIATIVE_TLB_LOOKUP_FILL_UNIT_ASSERT_SVH

// check that the consequent holds in the cycle after the antecedent
`define FATLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// check that the consequent holds in the same cycle as the antecedent
`define FATLB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/fatlb_pkg.sv -----
// Shared constants and types for the TLB lookup and fill unit
`timescale 1ns / 1ps
package fatlb_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int VA_W            = 64;
    localparam int SHIFT_W         = 5;
    localparam int PAGE_W          = 52;
    localparam int IDX_OUT_W       = 4;
    localparam int CNT_W           = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd30;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    typedef struct packed {
        logic fire;
        logic hit;
    } t_step;

endpackage

// ----- src/fatlb_in_stage.sv -----
// Page size register and input register with page number extraction
`timescale 1ns / 1ps
module fatlb_in_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fatlb_pkg::SHIFT_W-1:0]   i_cfg_wr_data,
    input  logic                            i_load,
    input  logic [fatlb_pkg::VA_W-1:0]      i_virtual_address,
    output logic [fatlb_pkg::VA_W-1:0]      o_va,
    output logic [fatlb_pkg::PAGE_W-1:0]    o_page
);
    import fatlb_pkg::*;

    logic [SHIFT_W-1:0] r_page_shift;
    logic [SHIFT_W-1:0] eff_shift;
    logic [VA_W-1:0]    shifted;
    logic [VA_W-1:0]    r_va;
    logic [PAGE_W-1:0]  r_page;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= SHIFT_RST;
        end else if (i_cfg_wr_en) begin
            r_page_shift <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_page_shift < SHIFT_MIN) begin
            eff_shift = SHIFT_MIN;
        end else if (r_page_shift > SHIFT_MAX) begin
            eff_shift = SHIFT_MAX;
        end else begin
            eff_shift = r_page_shift;
        end
        shifted = i_virtual_address >> eff_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_va   <= i_virtual_address;
            r_page <= shifted[PAGE_W-1:0];
        end
    end

    assign o_va   = r_va;
    assign o_page = r_page;

endmodule

// ----- src/fatlb_cam.sv -----
// Entry store with parallel match, fill slot choice and fill on miss
`timescale 1ns / 1ps
module fatlb_cam #(
    parameter int TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF,
    parameter int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [fatlb_pkg::PAGE_W-1:0]  i_page,
    output logic                          o_hit,
    output logic [IDX_W-1:0]              o_slot
);
    import fatlb_pkg::*;

    logic [TLB_ENTRIES-1:0] r_valid;
    logic [PAGE_W-1:0]      r_page [TLB_ENTRIES];
    logic                   hit;
    logic [IDX_W-1:0]       hit_slot;
    logic [IDX_W-1:0]       free_slot;
    logic [IDX_W-1:0]       slot;

    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_page[i] == i_page)) begin
                hit      = 1'b1;
                hit_slot = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_slot = IDX_W'(i);
            end
        end
        slot = hit ? hit_slot : free_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_fire && !hit) begin
            r_valid[slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && !hit) begin
            r_page[slot] <= i_page;
        end
    end

    assign o_hit  = hit;
    assign o_slot = slot;

endmodule

// ----- src/fatlb_out_stage.sv -----
// Saturating hit and miss counters and result register
`timescale 1ns / 1ps
module fatlb_out_stage #(
    parameter int TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF,
    parameter int IDX_W       = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fatlb_pkg::t_step                 i_step,
    input  logic [IDX_W-1:0]                 i_slot,
    input  logic [fatlb_pkg::VA_W-1:0]       i_va,
    output logic [fatlb_pkg::VA_W-1:0]       o_physical_address,
    output logic                             o_tlb_hit,
    output logic [fatlb_pkg::IDX_OUT_W-1:0]  o_entry_index,
    output logic [fatlb_pkg::CNT_W-1:0]      o_hit_count,
    output logic [fatlb_pkg::CNT_W-1:0]      o_miss_count
);
    import fatlb_pkg::*;

    localparam int EXT_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

    logic [CNT_W-1:0]     r_hits;
    logic [CNT_W-1:0]     r_misses;
    logic [VA_W-1:0]      r_pa;
    logic                 r_hit;
    logic [IDX_OUT_W-1:0] r_index;
    logic [EXT_W-1:0]     slot_ext;

    assign slot_ext = EXT_W'(i_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_step.fire) begin
            if (i_step.hit && (r_hits != CNT_MAX)) begin
                r_hits <= r_hits + 1'b1;
            end
            if (!i_step.hit && (r_misses != CNT_MAX)) begin
                r_misses <= r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.fire) begin
            r_pa    <= i_va;
            r_hit   <= i_step.hit;
            r_index <= slot_ext[IDX_OUT_W-1:0];
        end
    end

    assign o_physical_address = r_pa;
    assign o_tlb_hit          = r_hit;
    assign o_entry_index      = r_index;
    assign o_hit_count        = r_hits;
    assign o_miss_count       = r_misses;

endmodule

// ----- src/fully_associative_tlb_lookup_fill_unit.sv -----
// Fully associative TLB: one request per cycle while the result side takes results.
// A request enters the input register, where its page number is formed with the
// current page shift; in the next step all entries are compared at once, a miss
// fills the lowest free entry (entry 0 when full) and the result register is
// loaded together with the hit and miss counters. The combinational compare over
// every entry sets that rate. Page shift must be written through the configuration
// port only while idle, by the user; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "fully_associative_tlb_lookup_fill_unit_assert.svh"
module fully_associative_tlb_lookup_fill_unit #(
    parameter int TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [fatlb_pkg::SHIFT_W-1:0]    i_cfg_wr_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [fatlb_pkg::VA_W-1:0]       i_virtual_address,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fatlb_pkg::VA_W-1:0]       o_physical_address,
    output logic                             o_tlb_hit,
    output logic [fatlb_pkg::IDX_OUT_W-1:0]  o_entry_index,
    output logic [fatlb_pkg::CNT_W-1:0]      o_hit_count,
    output logic [fatlb_pkg::CNT_W-1:0]      o_miss_count
);
    import fatlb_pkg::*;

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              fire;
    logic              load;
    logic [VA_W-1:0]   s1_va;
    logic [PAGE_W-1:0] s1_page;
    logic              lookup_hit;
    logic [IDX_W-1:0]  lookup_slot;
    t_step             step;

    assign fire    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || fire;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_s1_valid  = load ? 1'b1 : (fire ? 1'b0 : r_s1_valid);
        n_out_valid = fire ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid   = r_out_valid;
    assign step.fire = fire;
    assign step.hit  = lookup_hit;

    fatlb_in_stage u_in_stage (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_load            (load),
        .i_virtual_address (i_virtual_address),
        .o_va              (s1_va),
        .o_page            (s1_page)
    );

    fatlb_cam #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_page  (s1_page),
        .o_hit   (lookup_hit),
        .o_slot  (lookup_slot)
    );

    fatlb_out_stage #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_out_stage (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_slot             (lookup_slot),
        .i_va               (s1_va),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_entry_index      (o_entry_index),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count)
    );

    `FATLB_ASSERT_NEXT(a_fire_gives_result, fire, o_valid, "lookup did not produce a result")
    `FATLB_ASSERT_NEXT(a_hit_counts, fire && lookup_hit && (o_hit_count != CNT_MAX), o_tlb_hit && (o_hit_count == CNT_W'($past(o_hit_count) + 1'b1)), "hit not counted")
    `FATLB_ASSERT_NEXT(a_miss_keeps_hits, fire && !lookup_hit, !o_tlb_hit && $stable(o_hit_count), "miss disturbed hit count")
    `FATLB_ASSERT_NOW(a_no_fire_when_blocked, r_out_valid && !i_ready, !fire, "result overwritten while stalled")

endmodule
